[design/efb_pkg.sv]
// Shared types and constants for the escape-framed byte deframer.
// No dependencies; every other design file but efb_ram uses this package.
`default_nettype none

package efb_pkg;

  localparam int BUFFER_DEPTH = 64;
  localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
  localparam int BYTE_W       = 8;
  localparam int INDEX_W      = 6;
  localparam int LENGTH_W     = 6;
  localparam int CFG_INDEX_W  = 1;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCOUNT_W     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_INDEX_W-1:0] REG_ESCAPE_CODE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_END_CODE    = 1'd1;

  localparam logic [BYTE_W-1:0] ESCAPE_CODE_RESET = 8'd92;
  localparam logic [BYTE_W-1:0] END_CODE_RESET    = 8'd48;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(BUFFER_DEPTH - 1);

  typedef struct packed {
    logic               mode;
    logic [BYTE_W-1:0]  rx_byte;
    logic [INDEX_W-1:0] read_index;
  } in_word_t;

  typedef struct packed {
    logic                frame_done;
    logic [BYTE_W-1:0]   frame_command;
    logic [LENGTH_W-1:0] frame_length;
    logic [BYTE_W-1:0]   read_data;
  } out_word_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_STORE,
    OP_COMMAND,
    OP_CLOSE,
    OP_READ
  } op_kind_t;

  typedef struct packed {
    op_kind_t           kind;
    logic [BYTE_W-1:0]  data;
    logic [INDEX_W-1:0] index;
  } op_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_COPY
  } bk_state_t;

  typedef struct packed {
    logic busy;
    logic take;
  } bk_status_t;

endpackage

`default_nettype wire

[design/efb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module efb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[design/efb_front.sv]
// Front end: takes input words, holds the code registers and the escape flag,
// and classifies each word into an operation for the back end. Uses efb_pkg.
`default_nettype none

module efb_front (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [efb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [efb_pkg::BYTE_W-1:0]      cfg_data,
  input  wire logic                           push,
  input  wire efb_pkg::in_word_t              item,
  input  wire logic                           q_full,
  output logic                                q_push,
  output efb_pkg::op_t                        q_op
);
  import efb_pkg::*;

  logic [BYTE_W-1:0] escape_code;
  logic [BYTE_W-1:0] end_code;
  logic              escape_pending;
  logic              escape_pending_next;

  assign q_push = push && !q_full;

  always_comb begin
    q_op.data           = item.rx_byte;
    q_op.index          = item.read_index;
    q_op.kind           = OP_NONE;
    escape_pending_next = escape_pending;
    priority if (item.mode) begin
      q_op.kind = OP_READ;
    end else if (item.rx_byte == escape_code) begin
      if (!escape_pending) begin
        escape_pending_next = 1'b1;
      end else begin
        escape_pending_next = 1'b0;
        q_op.kind           = OP_STORE;
      end
    end else if (escape_pending) begin
      escape_pending_next = 1'b0;
      q_op.kind           = (item.rx_byte != end_code) ? OP_COMMAND : OP_CLOSE;
    end else begin
      q_op.kind = OP_STORE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_code    <= ESCAPE_CODE_RESET;
      end_code       <= END_CODE_RESET;
      escape_pending <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ESCAPE_CODE: escape_code <= cfg_data;
          REG_END_CODE:    end_code    <= cfg_data;
          default:         ;
        endcase
      end
      if (q_push) begin
        escape_pending <= escape_pending_next;
      end
    end
  end

endmodule

`default_nettype wire

[design/efb_queue.sv]
// Short operation queue between the front end and the back end.
// Uses efb_pkg for the operation type and the queue depth.
`default_nettype none

module efb_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire efb_pkg::op_t  op_in,
  input  wire logic          pop,
  output efb_pkg::op_t       op_out,
  output logic               full,
  output logic               empty
);
  import efb_pkg::*;

  op_t                slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCOUNT_W-1:0] count;

  assign full   = (count == QCOUNT_W'(QUEUE_DEPTH));
  assign empty  = (count == '0);
  assign op_out = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= op_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

[design/efb_back.sv]
// Back end: carries out queued operations on the receive buffer and message
// store RAMs and holds the result register. Uses efb_pkg and efb_ram.
`default_nettype none

module efb_back (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         q_empty,
  input  wire efb_pkg::op_t q_op,
  input  wire logic         pop,
  output efb_pkg::bk_status_t status,
  output efb_pkg::out_word_t  result,
  output logic                empty
);
  import efb_pkg::*;

  bk_state_t           state, state_next;
  logic                out_valid, out_valid_next;
  out_word_t           out_word, out_word_next;
  logic [ADDR_W-1:0]   fill, fill_next;
  logic [BYTE_W-1:0]   command_reg, command_reg_next;
  logic [ADDR_W-1:0]   message_length, message_length_next;
  logic [ADDR_W-1:0]   cp_idx, cp_idx_next;
  logic [ADDR_W-1:0]   wr_addr, wr_addr_next;
  logic                wr_pend, wr_pend_next;
  logic                rd_done, rd_done_next;
  logic                in_range, in_range_next;
  logic                take;
  logic [ADDR_W-1:0]   last;
  out_word_t           plain;

  logic                rb_we;
  logic [BYTE_W-1:0]   rb_rdata;
  logic [BYTE_W-1:0]   ms_rdata;

  efb_ram #(.WIDTH(BYTE_W), .DEPTH(BUFFER_DEPTH)) u_receive_buffer (
    .clk   (clk),
    .we    (rb_we),
    .waddr (fill),
    .wdata (q_op.data),
    .raddr (cp_idx),
    .rdata (rb_rdata)
  );

  efb_ram #(.WIDTH(BYTE_W), .DEPTH(BUFFER_DEPTH)) u_message_store (
    .clk   (clk),
    .we    (wr_pend),
    .waddr (wr_addr),
    .wdata (rb_rdata),
    .raddr (ADDR_W'(q_op.index)),
    .rdata (ms_rdata)
  );

  assign take        = (state == BK_IDLE) && !q_empty && (!out_valid || pop);
  assign rb_we       = take && (q_op.kind == OP_STORE);
  assign last        = fill - 1'b1;
  assign status.take = take;
  assign status.busy = (state != BK_IDLE);
  assign result      = out_word;
  assign empty       = !out_valid;

  always_comb begin
    plain = '{frame_done: 1'b0, frame_command: '0,
              frame_length: LENGTH_W'(message_length), read_data: '0};

    state_next          = state;
    out_valid_next      = out_valid && !pop;
    out_word_next       = out_word;
    fill_next           = fill;
    command_reg_next    = command_reg;
    message_length_next = message_length;
    cp_idx_next         = cp_idx;
    wr_addr_next        = wr_addr;
    wr_pend_next        = 1'b0;
    rd_done_next        = rd_done;
    in_range_next       = in_range;

    unique case (state)
      BK_IDLE: begin
        if (take) begin
          unique case (q_op.kind)
            OP_STORE: begin
              fill_next      = (fill == LAST_ADDR) ? '0 : fill + 1'b1;
              out_word_next  = plain;
              out_valid_next = 1'b1;
            end
            OP_COMMAND: begin
              fill_next        = '0;
              command_reg_next = q_op.data;
              out_word_next    = plain;
              out_valid_next   = 1'b1;
            end
            OP_CLOSE: begin
              if (fill == '0) begin
                message_length_next = '0;
                out_word_next = '{frame_done: 1'b1, frame_command: command_reg,
                                  frame_length: '0, read_data: '0};
                out_valid_next = 1'b1;
              end else begin
                cp_idx_next  = '0;
                rd_done_next = 1'b0;
                state_next   = BK_COPY;
              end
            end
            OP_READ: begin
              in_range_next = (32'(q_op.index) < BUFFER_DEPTH);
              state_next    = BK_READ;
            end
            default: begin
              out_word_next  = plain;
              out_valid_next = 1'b1;
            end
          endcase
        end
      end
      BK_READ: begin
        out_word_next           = plain;
        out_word_next.read_data = in_range ? ms_rdata : '0;
        out_valid_next          = 1'b1;
        state_next              = BK_IDLE;
      end
      BK_COPY: begin
        if (!rd_done) begin
          wr_pend_next = 1'b1;
          wr_addr_next = cp_idx;
          if (cp_idx == last) begin
            rd_done_next = 1'b1;
          end else begin
            cp_idx_next = cp_idx + 1'b1;
          end
        end
        if (wr_pend && (wr_addr == last)) begin
          message_length_next = fill;
          out_word_next = '{frame_done: 1'b1, frame_command: command_reg,
                            frame_length: LENGTH_W'(fill), read_data: '0};
          out_valid_next = 1'b1;
          state_next     = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= BK_IDLE;
      out_valid      <= 1'b0;
      fill           <= '0;
      command_reg    <= '0;
      message_length <= '0;
      wr_pend        <= 1'b0;
      rd_done        <= 1'b0;
    end else begin
      state          <= state_next;
      out_valid      <= out_valid_next;
      fill           <= fill_next;
      command_reg    <= command_reg_next;
      message_length <= message_length_next;
      wr_pend        <= wr_pend_next;
      rd_done        <= rd_done_next;
    end
  end

  always_ff @(posedge clk) begin
    out_word <= out_word_next;
    cp_idx   <= cp_idx_next;
    wr_addr  <= wr_addr_next;
    in_range <= in_range_next;
  end

endmodule

`default_nettype wire

[design/escape_framed_byte_deframer.sv]
// Top level of the escape-framed byte deframer.
// Uses efb_pkg, efb_front, efb_queue and efb_back.
//
// Each input word is either a received byte (mode 0) or a read of the message
// store (mode 1); every word yields exactly one result word. The front end
// accepts a word per cycle into a two-entry queue while the queue is not full.
// A plain byte, an escape or a command is handled straight from idle, a store
// read goes through the read state, and a frame end with a non-empty buffer
// copies the receive buffer into the message store through the buffer RAM's
// one read port. Message store entries that were never written read back
// undefined. The code registers must be written only while no word is in
// flight; the block itself does not enforce this.
`default_nettype none

module escape_framed_byte_deframer (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [efb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [efb_pkg::BYTE_W-1:0]      cfg_data,
  input  wire logic                            push,
  output logic                                 full,
  input  wire efb_pkg::in_word_t               item,
  output logic                                 empty,
  input  wire logic                            pop,
  output efb_pkg::out_word_t                   result
);
  import efb_pkg::*;

  logic       q_push;
  op_t        q_op_in;
  op_t        q_op_out;
  logic       q_empty;
  bk_status_t bk_status;

  efb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .item      (item),
    .q_full    (full),
    .q_push    (q_push),
    .q_op      (q_op_in)
  );

  efb_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .op_in  (q_op_in),
    .pop    (bk_status.take),
    .op_out (q_op_out),
    .full   (full),
    .empty  (q_empty)
  );

  efb_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_op    (q_op_out),
    .pop     (pop),
    .status  (bk_status),
    .result  (result),
    .empty   (empty)
  );

  a_take_needs_word: assert property (@(posedge clk) disable iff (rst)
    bk_status.take |-> !q_empty)
    else $error("back end took a word from an empty queue");

  a_busy_no_result: assert property (@(posedge clk) disable iff (rst)
    bk_status.busy |-> empty)
    else $error("result register occupied during a read or copy");

  a_take_frees_result: assert property (@(posedge clk) disable iff (rst)
    (bk_status.take && !empty) |-> pop)
    else $error("back end took a word while a result was still held");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("queues not cleared by reset");

endmodule

`default_nettype wire
